>>> rtl/sfsr_pkg.sv
// Shared types and constants for the signed fixed-point square root.
// Used by every module of the block; depends on nothing.
package sfsr_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int LIMIT_W   = 31;
  localparam int OUT_W     = 25;

  localparam int RAD_RAW_W = DATA_W + FRAC_BITS;
  localparam int RAD_W     = RAD_RAW_W + (RAD_RAW_W % 2);
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 1;

  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = (ROOT_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam longint unsigned LIMIT_MAX  = (64'd1 << LIMIT_W) - 64'd1;
  localparam longint unsigned LIMIT_FULL = 64'd100 << FRAC_BITS;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET =
    (LIMIT_FULL > LIMIT_MAX) ? LIMIT_W'(LIMIT_MAX) : LIMIT_W'(LIMIT_FULL);

  typedef struct packed {
    logic              neg;
    logic              over;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] res;
  } sfsr_item_t;

endpackage

>>> rtl/sfsr_front.sv
// Input stage: magnitude, limit check and radicand setup.
// Depends on sfsr_pkg.
module sfsr_front import sfsr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DATA_W-1:0]  operand,
  input  logic [LIMIT_W-1:0] limit,
  output logic               out_valid,
  input  logic               out_ready,
  output sfsr_item_t         out_item
);

  logic        valid_r;
  sfsr_item_t  item_r;
  sfsr_item_t  item_nxt;
  logic        neg;
  logic [DATA_W-1:0] mag;
  logic        over;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    neg  = operand[DATA_W-1];
    mag  = neg ? (~operand + DATA_W'(1)) : operand;
    over = mag > DATA_W'(limit);
    item_nxt.neg  = neg && !over;
    item_nxt.over = over;
    item_nxt.rad  = over ? '0 : (RAD_W'(mag) << FRAC_BITS);
    item_nxt.rem  = '0;
    item_nxt.res  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> rtl/sfsr_root_stage.sv
// One pipeline stage of the digit-by-digit root, a few result bits per stage.
// Depends on sfsr_pkg.
module sfsr_root_stage import sfsr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sfsr_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output sfsr_item_t out_item
);

  logic       valid_r;
  sfsr_item_t item_r;
  sfsr_item_t item_nxt;
  logic [REM_W+1:0] cat;
  logic [REM_W+1:0] trial;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    item_nxt = in_item;
    cat      = '0;
    trial    = '0;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      cat   = {item_nxt.rem, item_nxt.rad[RAD_W-1 -: 2]};
      trial = (REM_W + 2)'({item_nxt.res, 2'b01});
      item_nxt.rad = item_nxt.rad << 2;
      if (cat >= trial) begin
        item_nxt.rem = REM_W'(cat - trial);
        item_nxt.res = {item_nxt.res[ROOT_W-2:0], 1'b1};
      end else begin
        item_nxt.rem = REM_W'(cat);
        item_nxt.res = {item_nxt.res[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> rtl/sfsr_back.sv
// Output register: applies the sign and holds the result word for the receiver.
// Depends on sfsr_pkg.
module sfsr_back import sfsr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sfsr_item_t              in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] root,
  output logic                    over_limit
);

  logic                    valid_r;
  logic signed [OUT_W-1:0] root_r;
  logic signed [OUT_W-1:0] root_nxt;
  logic                    over_r;
  logic [OUT_W-1:0]        mag;

  assign in_ready   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign root       = root_r;
  assign over_limit = over_r;

  always_comb begin
    mag      = OUT_W'(in_item.res);
    root_nxt = in_item.neg ? signed'(~mag + OUT_W'(1)) : signed'(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      root_r <= root_nxt;
      over_r <= in_item.over;
    end
  end

endmodule

>>> rtl/signed_fixed_square_root.sv
// Top level of the signed fixed-point square root pipeline.
// Depends on sfsr_pkg, sfsr_front, sfsr_root_stage and sfsr_back.
//
// The input channel (in_valid, in_ready, in_operand) takes a signed Q15.16
// word. The result channel (out_valid, out_ready, out_root, out_over_limit)
// returns one word per input word, in order: the floor of the square root of
// the magnitude in Q.16, carrying the input's sign, or zero with
// out_over_limit set when the magnitude exceeds the limit register.
// The limit is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, as the block does not enforce this. A word
// passes eight registers: one input stage, six root stages of four result
// bits each, and one output register. One word can enter in every cycle
// while the receiver takes results. Each stage holds its word when the stage
// after it cannot take it, so a stalled receiver fills the pipeline and then
// drops in_ready; gaps in the pipeline close up meanwhile. Nothing is lost
// or repeated. Reset clears all valid bits and sets the limit to 100.0.
module signed_fixed_square_root import sfsr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DATA_W-1:0] in_operand,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_root,
  output logic                    out_over_limit,
  input  logic                    cfg_we,
  input  logic [LIMIT_W-1:0]      cfg_wdata
);

  logic [LIMIT_W-1:0] limit_r;
  logic [NUM_STAGES:0] stg_valid;
  logic [NUM_STAGES:0] stg_ready;
  sfsr_item_t          stg_item [NUM_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  sfsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operand   (in_operand),
    .limit     (limit_r),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_item  (stg_item[0])
  );

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    sfsr_root_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_item   (stg_item[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_item  (stg_item[g+1])
    );
  end

  sfsr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stg_valid[NUM_STAGES]),
    .in_ready   (stg_ready[NUM_STAGES]),
    .in_item    (stg_item[NUM_STAGES]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .root       (out_root),
    .over_limit (out_over_limit)
  );

endmodule

>>> rtl/sfsr_checker.sv
// Port-level checks for the signed fixed-point square root.
// Depends on sfsr_pkg; bound to signed_fixed_square_root.
module sfsr_checker import sfsr_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic signed [DATA_W-1:0] in_operand,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [OUT_W-1:0]  out_root,
  input logic                     out_over_limit,
  input logic                     cfg_we,
  input logic [LIMIT_W-1:0]       cfg_wdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_root) && $stable(out_over_limit))
    else $error("stalled result word changed");

  a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_over_limit |-> out_root == '0)
    else $error("over-limit result with nonzero root");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output register is empty");

endmodule

bind signed_fixed_square_root sfsr_checker u_sfsr_checker (.*);
